[sv/caprng_pkg.sv]
package caprng_pkg;

    // request types (s_axis_tuser)
    localparam logic [1:0] REQ_OFFER  = 2'd0;
    localparam logic [1:0] REQ_DRAIN  = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    // result kinds (m_axis_tuser)
    localparam logic [2:0] KIND_OK       = 3'd0;
    localparam logic [2:0] KIND_RD_ERR   = 3'd1;
    localparam logic [2:0] KIND_FILT_ERR = 3'd2;
    localparam logic [2:0] KIND_STATUS   = 3'd3;
    localparam logic [2:0] KIND_EMPTY    = 3'd4;

    // stored entry class
    localparam logic [1:0] CLS_OK       = 2'd0;
    localparam logic [1:0] CLS_RD_ERR   = 2'd1;
    localparam logic [1:0] CLS_FILT_ERR = 2'd2;

    // offered count at which the block closes itself
    localparam logic [62:0] WRAP_GUARD = 63'h7FFF_FFFF_FFFF_FFFD;

    // output queue
    localparam int Q_DEPTH = 4;
    localparam int QAW     = $clog2(Q_DEPTH);
    localparam int QLW     = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        midi_word;
        logic signed [31:0] event_timestamp;
        logic [63:0]        capture_time_bits;
        logic [31:0]        filter_bits;
        logic signed [31:0] error_code;
        logic               filter_failed;
        logic [62:0]        drain_through;
    } t_req;

    typedef struct packed {
        logic [62:0]        seq;
        logic [63:0]        capture_time;
        logic [31:0]        midi_word;
        logic signed [31:0] timestamp;
        logic [31:0]        filter_bits;
        logic signed [31:0] error_code;
        logic [1:0]         cls;
    } t_entry;

    typedef struct packed {
        logic [2:0]         result_kind;
        logic               last_of_run;
        logic [62:0]        sequence_or_offered;
        logic [63:0]        out_capture_time;
        logic [31:0]        out_midi_word;
        logic signed [31:0] out_timestamp;
        logic [31:0]        out_filter_bits;
        logic signed [31:0] out_error_code;
        logic [62:0]        written_count;
        logic [62:0]        dropped_count;
        logic [62:0]        read_error_count;
        logic               is_closed;
    } t_result;

endpackage

[sv/caprng_ring.sv]
module caprng_ring #(
    parameter int RING_DEPTH = 256,
    parameter int AW         = 8
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  caprng_pkg::t_entry    i_wr_data,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output caprng_pkg::t_entry    o_rd_data
);
    import caprng_pkg::*;

    t_entry r_mem [RING_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read: data is valid the cycle after i_rd_en
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/caprng_outq.sv]
module caprng_outq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  caprng_pkg::t_result        i_push_data,
    output logic [caprng_pkg::QLW-1:0] o_level,
    output logic                       o_valid,
    input  logic                       i_ready,
    output caprng_pkg::t_result        o_data
);
    import caprng_pkg::*;

    t_result        r_buf [Q_DEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QLW-1:0] r_level;
    logic           w_pop;

    assign o_valid = (r_level != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_buf[r_rd_ptr];
    assign o_level = r_level;

    // producer never pushes into a full queue (credit checked upstream)
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            if (i_push && !w_pop) begin
                r_level <= r_level + QLW'(1);
            end else if (!i_push && w_pop) begin
                r_level <= r_level - QLW'(1);
            end
        end
    end

endmodule

[sv/caprng_ctrl.sv]
module caprng_ctrl #(
    parameter int RING_DEPTH  = 256,
    parameter int DRAIN_LIMIT = 16,
    parameter int AW          = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  caprng_pkg::t_req           i_req,
    output logic                       o_push,
    output caprng_pkg::t_result        o_push_data,
    input  logic [caprng_pkg::QLW-1:0] i_q_level,
    output logic                       o_wr_en,
    output logic [AW-1:0]              o_wr_addr,
    output caprng_pkg::t_entry         o_wr_data,
    output logic                       o_rd_en,
    output logic [AW-1:0]              o_rd_addr,
    input  caprng_pkg::t_entry         i_rd_data
);
    import caprng_pkg::*;

    localparam int UW = $clog2(RING_DEPTH + 1);
    localparam int CW = $clog2(DRAIN_LIMIT + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_STATUS, ST_DRAIN} t_state;

    t_state        r_state;
    logic [2:0]    r_kind;
    logic [62:0]   r_head;
    logic [62:0]   r_tail;
    logic [62:0]   r_offered;
    logic [62:0]   r_dropped;
    logic [62:0]   r_rderr;
    logic          r_closed;
    logic [UW-1:0] r_used;
    logic [AW-1:0] r_wr_idx;
    logic [AW-1:0] r_rd_idx;
    logic [62:0]   r_limit;
    logic [CW-1:0] r_drn_cnt;
    logic          r_rd_valid;
    logic          r_rd_last;

    logic          w_room;
    logic          w_accept;
    logic          w_is_err;
    logic          w_guard;
    logic          w_full;
    logic          w_store;
    logic          w_empty;
    logic [62:0]   w_limit;
    logic          w_issue;
    logic          w_last;
    logic [62:0]   n_offered;
    logic [62:0]   n_tail;
    logic [1:0]    w_cls;

    // free queue slots must cover the read in flight plus the next push
    assign w_room = ({1'b0, i_q_level} + (QLW+1)'(r_rd_valid)) < (QLW+1)'(Q_DEPTH);

    assign o_req_ready = (r_state == ST_IDLE) && w_room;
    assign w_accept    = i_req_valid && o_req_ready;

    // offer decode
    assign w_is_err  = i_req.error_code[31];
    assign w_guard   = (r_offered >= WRAP_GUARD);
    assign w_full    = (r_used == UW'(RING_DEPTH));
    assign n_offered = r_offered + 63'd1;
    assign w_store   = w_accept && (i_req.req_type == REQ_OFFER) && !r_closed
                       && !w_guard && !w_full;
    assign w_cls     = !w_is_err ? CLS_OK :
                       (i_req.filter_failed ? CLS_FILT_ERR : CLS_RD_ERR);

    assign o_wr_en   = w_store;
    assign o_wr_addr = r_wr_idx;
    assign o_wr_data = '{seq:          n_offered,
                         capture_time: i_req.capture_time_bits,
                         midi_word:    i_req.midi_word,
                         timestamp:    i_req.event_timestamp,
                         filter_bits:  i_req.filter_bits,
                         error_code:   i_req.error_code,
                         cls:          w_cls};

    // drain bound: min(drain_through, head); tail never passes head
    assign w_empty = (r_tail >= i_req.drain_through) || (r_tail == r_head);
    assign w_limit = (i_req.drain_through < r_head) ? i_req.drain_through : r_head;

    assign w_issue   = (r_state == ST_DRAIN) && w_room;
    assign n_tail    = r_tail + 63'd1;
    assign w_last    = (n_tail == r_limit) || (r_drn_cnt == CW'(DRAIN_LIMIT - 1));
    assign o_rd_en   = w_issue;
    assign o_rd_addr = r_rd_idx;

    // one push per cycle: a drain read returning, or a status/empty result
    assign o_push = r_rd_valid || (r_state == ST_STATUS);

    always_comb begin
        o_push_data                  = '0;
        o_push_data.written_count    = r_head;
        o_push_data.dropped_count    = r_dropped;
        o_push_data.read_error_count = r_rderr;
        o_push_data.is_closed        = r_closed;
        if (r_rd_valid) begin
            o_push_data.result_kind         = {1'b0, i_rd_data.cls};
            o_push_data.last_of_run         = r_rd_last;
            o_push_data.sequence_or_offered = i_rd_data.seq;
            o_push_data.out_capture_time    = i_rd_data.capture_time;
            o_push_data.out_midi_word       = i_rd_data.midi_word;
            o_push_data.out_timestamp       = i_rd_data.timestamp;
            o_push_data.out_filter_bits     = i_rd_data.filter_bits;
            o_push_data.out_error_code      = i_rd_data.error_code;
        end else begin
            o_push_data.result_kind         = r_kind;
            o_push_data.last_of_run         = 1'b1;
            o_push_data.sequence_or_offered = (r_kind == KIND_STATUS) ? r_offered : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_kind     <= KIND_STATUS;
            r_head     <= '0;
            r_tail     <= '0;
            r_offered  <= '0;
            r_dropped  <= '0;
            r_rderr    <= '0;
            r_closed   <= 1'b0;
            r_used     <= '0;
            r_wr_idx   <= '0;
            r_rd_idx   <= '0;
            r_drn_cnt  <= '0;
            r_rd_valid <= 1'b0;
            r_rd_last  <= 1'b0;
        end else begin
            r_rd_valid <= w_issue;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        unique case (i_req.req_type)
                            REQ_OFFER: begin
                                r_kind  <= KIND_STATUS;
                                r_state <= ST_STATUS;
                                if (!r_closed) begin
                                    if (w_guard) begin
                                        r_closed <= 1'b1;
                                    end else begin
                                        r_offered <= n_offered;
                                        if (w_is_err && !i_req.filter_failed) begin
                                            r_rderr <= r_rderr + 63'd1;
                                        end
                                        if (w_full) begin
                                            r_dropped <= r_dropped + 63'd1;
                                        end else begin
                                            r_head   <= r_head + 63'd1;
                                            r_used   <= r_used + UW'(1);
                                            r_wr_idx <= (r_wr_idx == AW'(RING_DEPTH - 1)) ?
                                                        '0 : r_wr_idx + AW'(1);
                                        end
                                    end
                                end
                            end
                            REQ_DRAIN: begin
                                r_limit   <= w_limit;
                                r_drn_cnt <= '0;
                                if (w_empty) begin
                                    r_kind  <= KIND_EMPTY;
                                    r_state <= ST_STATUS;
                                end else begin
                                    r_state <= ST_DRAIN;
                                end
                            end
                            REQ_FINISH: begin
                                r_closed <= 1'b1;
                                r_kind   <= KIND_STATUS;
                                r_state  <= ST_STATUS;
                            end
                            default: begin
                                // unused request type: taken, no result
                            end
                        endcase
                    end
                end
                ST_STATUS: begin
                    r_state <= ST_IDLE;
                end
                ST_DRAIN: begin
                    if (w_issue) begin
                        r_rd_last <= w_last;
                        r_tail    <= n_tail;
                        r_used    <= r_used - UW'(1);
                        r_drn_cnt <= r_drn_cnt + CW'(1);
                        r_rd_idx  <= (r_rd_idx == AW'(RING_DEPTH - 1)) ?
                                     '0 : r_rd_idx + AW'(1);
                        if (w_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/capture_ring_with_drop_counters.sv]
// Offer and finish: taken in ST_IDLE; ST_STATUS pushes the result to the output queue, and
//   the next item can be taken back in ST_IDLE. Drain: ST_DRAIN reads one entry per cycle
//   while the queue has room, set by the single read port of the ring memory; each read
//   is registered, then pushed; ST_IDLE follows the last read. An empty drain uses ST_STATUS.
// Reset (i_rst_n low, synchronous) clears counters, pointers, the closed flag and the output
//   queue; ring memory contents are not cleared, there is no clearing pass.
module capture_ring_with_drop_counters #(
    parameter int RING_DEPTH  = 256,
    parameter int DRAIN_LIMIT = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] midi_word, [63:32] event_timestamp, [127:64] capture_time_bits,
    // [159:128] filter_bits, [191:160] error_code, [192] filter_failed,
    // [255:193] drain_through
    input  logic [255:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]   s_axis_tuser,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [62:0] sequence_or_offered, [126:63] out_capture_time, [158:127] out_midi_word,
    // [190:159] out_timestamp, [222:191] out_filter_bits, [254:223] out_error_code,
    // [317:255] written_count, [380:318] dropped_count, [443:381] read_error_count,
    // [444] is_closed, [447:445] zero
    output logic [447:0] m_axis_tdata,
    // [2:0] result_kind
    output logic [2:0]   m_axis_tuser,
    // last_of_run
    output logic         m_axis_tlast
);
    import caprng_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    t_req           w_req;
    t_result        w_push_data;
    t_result        w_out;
    logic           w_push;
    logic [QLW-1:0] w_q_level;
    logic           w_wr_en;
    logic [AW-1:0]  w_wr_addr;
    t_entry         w_wr_data;
    logic           w_rd_en;
    logic [AW-1:0]  w_rd_addr;
    t_entry         w_rd_data;

    // unpack the input item
    assign w_req.req_type          = s_axis_tuser;
    assign w_req.midi_word         = s_axis_tdata[31:0];
    assign w_req.event_timestamp   = s_axis_tdata[63:32];
    assign w_req.capture_time_bits = s_axis_tdata[127:64];
    assign w_req.filter_bits       = s_axis_tdata[159:128];
    assign w_req.error_code        = s_axis_tdata[191:160];
    assign w_req.filter_failed     = s_axis_tdata[192];
    assign w_req.drain_through     = s_axis_tdata[255:193];

    // request sequencer: counters, pointers, offer writes and drain reads
    caprng_ctrl #(
        .RING_DEPTH  (RING_DEPTH),
        .DRAIN_LIMIT (DRAIN_LIMIT),
        .AW          (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (w_req),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_q_level   (w_q_level),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

    // ring storage, one write and one read port
    caprng_ring #(
        .RING_DEPTH (RING_DEPTH),
        .AW         (AW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // small result queue decouples output stalls from the ring read pipe
    caprng_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_level     (w_q_level),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (w_out)
    );

    // pack the result item
    assign m_axis_tuser = w_out.result_kind;
    assign m_axis_tlast = w_out.last_of_run;
    assign m_axis_tdata = {3'b000,
                           w_out.is_closed,
                           w_out.read_error_count,
                           w_out.dropped_count,
                           w_out.written_count,
                           w_out.out_error_code,
                           w_out.out_filter_bits,
                           w_out.out_timestamp,
                           w_out.out_midi_word,
                           w_out.out_capture_time,
                           w_out.sequence_or_offered};

endmodule
